// ===== design/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// shared sizes, codes and helpers for the double-ended queue store
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 5;
  localparam int CMD_W    = 3;
  localparam int STS_W    = 2;
  localparam int M_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_OVER  = 2'd2
  } sts_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } state_e;

  // fold a value below twice the ring size back onto a slot index
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] v);
    logic [CNT_W:0] lim;
    lim = (CNT_W + 1)'(DEPTH);
    if (v >= lim) begin
      return IDX_W'(v - lim);
    end
    return IDX_W'(v);
  endfunction

endpackage

// ===== design/dqs_ram.sv =====
// ----------------------------------------------------------------------------
// dqs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/double_ended_queue_store_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_store_core
// bounded deque of signed 32-bit values kept in a ring memory
// ----------------------------------------------------------------------------
// Each input item carries a command in tuser and a value in tdata. A push
// answers with the stored value, or with an overflow status when the ring
// is full. A pop reads the element from a ram with registered read data and
// answers with the removed value, or with an empty status. A dump answers an
// empty ring with an empty status; else it starts a ram read and streams one
// element per cycle from front to rear while the output is not stalled, with
// tlast on the final one; the single ram read port sets that pace. Every
// result carries the occupancy after its step. Unused command codes are taken
// and dropped without a result. A new item is taken only in the idle state,
// when the output register is empty or its result is taken in the same cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_store_core
  import dqs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [VAL_W-1:0]    s_axis_tdata_i,  // value
  input  logic [CMD_W-1:0]    s_axis_tuser_i,  // command
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,  // value_res, occupancy, zero pad
  output logic [STS_W-1:0]    m_axis_tuser_o,  // status
  output logic                m_axis_tlast_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  logic             m_valid_q, m_valid_d;
  sts_e             sts_q, sts_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             last_q, last_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  logic             out_free;
  logic             accept;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic [IDX_W-1:0] head_dec, head_inc, ptr_inc;
  logic             full, empty;

  dqs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s_axis_tdata_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(DEPTH));
  assign empty           = (count_q == '0);
  assign head_dec        = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc        = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign ptr_inc         = (ptr_q == IDX_W'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    sts_d     = sts_q;
    val_d     = val_q;
    last_d    = last_q;
    occ_d     = occ_q;
    ram_we    = 1'b0;
    ram_waddr = head_dec;
    ram_re    = 1'b0;
    ram_raddr = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(s_axis_tuser_i))
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              m_valid_d = 1'b1;
              last_d    = 1'b1;
              if (full) begin
                sts_d = STS_OVER;
                val_d = '0;
                occ_d = OCC_W'(count_q);
              end else begin
                ram_we = 1'b1;
                if (cmd_e'(s_axis_tuser_i) == CMD_PUSH_FRONT) begin
                  ram_waddr = head_dec;
                  head_d    = head_dec;
                end else begin
                  ram_waddr = wrap_idx((CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q));
                end
                count_d = count_q + 1'b1;
                sts_d   = STS_OK;
                val_d   = s_axis_tdata_i;
                occ_d   = OCC_W'(count_q + 1'b1);
              end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
              if (empty) begin
                m_valid_d = 1'b1;
                last_d    = 1'b1;
                sts_d     = STS_EMPTY;
                val_d     = '0;
                occ_d     = '0;
              end else begin
                ram_re = 1'b1;
                if (cmd_e'(s_axis_tuser_i) == CMD_POP_FRONT) begin
                  ram_raddr = head_q;
                  head_d    = head_inc;
                end else begin
                  ram_raddr = wrap_idx((CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q)
                                       - 1'b1);
                end
                count_d = count_q - 1'b1;
                state_d = ST_POP;
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                m_valid_d = 1'b1;
                last_d    = 1'b1;
                sts_d     = STS_EMPTY;
                val_d     = '0;
                occ_d     = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                ptr_d     = head_q;
                idx_d     = '0;
                state_d   = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sts_d     = STS_OK;
          val_d     = ram_rdata;
          last_d    = 1'b1;
          occ_d     = OCC_W'(count_q);
          state_d   = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          sts_d     = STS_OK;
          val_d     = ram_rdata;
          occ_d     = OCC_W'(count_q);
          last_d    = (idx_q == count_q - 1'b1);
          if (idx_q == count_q - 1'b1) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc;
            ptr_d     = ptr_inc;
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    ptr_q  <= ptr_d;
    sts_q  <= sts_d;
    val_q  <= val_d;
    last_q <= last_d;
    occ_q  <= occ_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(M_DATA_W - VAL_W - OCC_W)'(0), occ_q, val_q};
  assign m_axis_tuser_o  = sts_q;
  assign m_axis_tlast_o  = last_q;

endmodule
